FILE: rtl/base58_address_encoder_assert.svh
// ---------------------------------------------------------------------------
// Base58 address encoder assertion macros
// Assertion shorthands that are clocked on clk and disabled during reset.
// In synthesis builds they expand to nothing.
// ---------------------------------------------------------------------------
`ifndef BASE58_ADDRESS_ENCODER_ASSERT_SVH
`define BASE58_ADDRESS_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define B58E_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base58 encoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define B58E_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base58 encoder assertion failed");

`else

`define B58E_ASSERT_IMP(label, ante, cons)
`define B58E_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: rtl/b58e_pkg.sv
// ---------------------------------------------------------------------------
// Base58 address encoder package
// Command word type, the divide-by-58 step and the base58 alphabet.
// ---------------------------------------------------------------------------
package b58e_pkg;

    localparam int unsigned RADIX      = 58;
    localparam int unsigned RECIP_MULT = 565;  // ceil(2^15 / 58)
    localparam int unsigned RECIP_SHR  = 15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // shift an input byte into the number buffer
        logic div_step;   // run one byte of the long division
        logic div_first;  // this step starts a new division (remainder zero)
        logic div_last;   // this step ends a division: push the digit
        logic emit;       // move the top digit into the output register
        logic emit_last;  // the emitted character ends the string
    } b58e_cmd_t;

    // Result of one long-division step.
    typedef struct packed {
        logic [7:0] quot;
        logic [5:0] rem;
    } b58e_div_t;

    // One byte of long division by 58, using 256 = 4*58 + 24.
    // The partial value stays below 1624, so a reciprocal multiply is exact.
    function automatic b58e_div_t b58e_div_step(input logic [5:0] rem_in,
                                                input logic [7:0] byte_in);
        logic [10:0] part;
        logic [20:0] prod;
        logic [4:0]  qpart;
        logic [10:0] back;
        logic [10:0] rem_full;
        b58e_div_t   res;
        part     = 11'(rem_in) * 11'd24 + 11'(byte_in);
        prod     = 21'(part) * 21'(RECIP_MULT);
        qpart    = prod[RECIP_SHR +: 5];
        back     = 11'(qpart) * 11'(RADIX);
        rem_full = part - back;
        res.quot = {rem_in[5:0], 2'b00} + 8'(qpart);
        res.rem  = rem_full[5:0];
        return res;
    endfunction

    // ASCII code of a base58 digit; codes above 57 map to the last character.
    function automatic logic [6:0] b58e_char(input logic [5:0] digit);
        logic [6:0] d;
        logic [6:0] code;
        d = 7'(digit);
        if (d <= 7'd8) begin
            code = d + 7'd49;   // '1'..'9'
        end else if (d <= 7'd16) begin
            code = d + 7'd56;   // 'A'..'H'
        end else if (d <= 7'd21) begin
            code = d + 7'd57;   // 'J'..'N'
        end else if (d <= 7'd32) begin
            code = d + 7'd58;   // 'P'..'Z'
        end else if (d <= 7'd43) begin
            code = d + 7'd64;   // 'a'..'k'
        end else if (d <= 7'd57) begin
            code = d + 7'd65;   // 'm'..'z'
        end else begin
            code = 7'd122;      // clamp to 'z'
        end
        return code;
    endfunction

endpackage

FILE: rtl/b58e_dp.sv
// ---------------------------------------------------------------------------
// Base58 encoder datapath
// Number buffer as a circular shift line, the divide-by-58 step, a digit
// stack and the output character register.
// ---------------------------------------------------------------------------
module b58e_dp #(
    parameter int NUMBER_BYTES = 25,
    parameter int OUTPUT_CHARS = 34
) (
    input  logic               clk,
    input  b58e_pkg::b58e_cmd_t cmd,
    input  logic [7:0]         byte_value,
    output logic [6:0]         char_code,
    output logic               last_char
);
    import b58e_pkg::*;

    logic [7:0] num_reg [NUMBER_BYTES];
    logic [5:0] dig_reg [OUTPUT_CHARS];
    logic [5:0] rem_reg;
    logic [5:0] rem_in;
    logic [7:0] shift_in;
    logic [6:0] char_reg;
    logic       last_reg;
    b58e_div_t  step;

    // One division step on the byte at the head of the buffer.
    assign rem_in   = cmd.div_first ? 6'd0 : rem_reg;
    assign step     = b58e_div_step(rem_in, num_reg[0]);
    assign shift_in = cmd.load ? byte_value : step.quot;

    // The buffer rotates: the head byte leaves and its quotient enters at
    // the tail, so after a full pass the bytes are back in order.
    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.div_step)
        begin
            for (int i = 0; i < NUMBER_BYTES - 1; i++)
            begin
                num_reg[i] <= num_reg[i + 1];
            end
            num_reg[NUMBER_BYTES - 1] <= shift_in;
        end
        if (cmd.div_step)
        begin
            rem_reg <= step.rem;
        end
    end

    // Digits are pushed least significant first and popped from the top,
    // which gives the most significant character first.
    always_ff @(posedge clk)
    begin
        if (cmd.div_last)
        begin
            dig_reg[0] <= step.rem;
            for (int i = 1; i < OUTPUT_CHARS; i++)
            begin
                dig_reg[i] <= dig_reg[i - 1];
            end
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < OUTPUT_CHARS - 1; i++)
            begin
                dig_reg[i] <= dig_reg[i + 1];
            end
        end
    end

    // Output character register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= b58e_char(dig_reg[0]);
            last_reg <= cmd.emit_last;
        end
    end

    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

FILE: rtl/b58e_ctrl.sv
// ---------------------------------------------------------------------------
// Base58 encoder controller
// Sequences loading, the repeated long division and character output, and
// owns the handshakes of both channels.
// ---------------------------------------------------------------------------
`include "base58_address_encoder_assert.svh"

module b58e_ctrl #(
    parameter int NUMBER_BYTES = 25,
    parameter int OUTPUT_CHARS = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output b58e_pkg::b58e_cmd_t cmd
);
    import b58e_pkg::*;

    localparam int CNT_W = (NUMBER_BYTES > 1) ? $clog2(NUMBER_BYTES) : 1;
    localparam int DIG_W = (OUTPUT_CHARS > 1) ? $clog2(OUTPUT_CHARS) : 1;
    localparam logic [CNT_W-1:0] BYTE_LAST = CNT_W'(NUMBER_BYTES - 1);
    localparam logic [DIG_W-1:0] DIG_LAST  = DIG_W'(OUTPUT_CHARS - 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] byte_cnt_reg;
    logic [DIG_W-1:0] digit_cnt_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             in_fire;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Command decode.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load = in_fire;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (byte_cnt_reg == '0);
                cmd.div_last  = (byte_cnt_reg == BYTE_LAST);
            end
            ST_EMIT:
            begin
                cmd.emit      = out_free;
                cmd.emit_last = (digit_cnt_reg == DIG_LAST);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // State, counters and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            byte_cnt_reg  <= '0;
            digit_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (byte_cnt_reg == BYTE_LAST)
                        begin
                            byte_cnt_reg <= '0;
                            state_reg    <= ST_DIV;
                        end
                        else
                        begin
                            byte_cnt_reg <= byte_cnt_reg + 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (byte_cnt_reg == BYTE_LAST)
                    begin
                        byte_cnt_reg <= '0;
                        if (digit_cnt_reg == DIG_LAST)
                        begin
                            digit_cnt_reg <= '0;
                            state_reg     <= ST_EMIT;
                        end
                        else
                        begin
                            digit_cnt_reg <= digit_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        byte_cnt_reg <= byte_cnt_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (cmd.emit)
                    begin
                        if (cmd.emit_last)
                        begin
                            digit_cnt_reg <= '0;
                            state_reg     <= ST_LOAD;
                        end
                        else
                        begin
                            digit_cnt_reg <= digit_cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    // A pending word is never overwritten.
    `B58E_ASSERT_IMP(a_no_overwrite, out_valid_reg && !out_ready, !cmd.emit)
    // The division phase always starts from clean counters.
    `B58E_ASSERT_IMP(a_div_start_clean,
        state_reg == ST_DIV && $past(state_reg) == ST_LOAD,
        byte_cnt_reg == '0 && digit_cnt_reg == '0)
    // The final character hands control back to loading.
    `B58E_ASSERT_NXT(a_last_to_load, cmd.emit && cmd.emit_last,
        state_reg == ST_LOAD && out_valid_reg)
    // Loading and dividing never overlap.
    `B58E_ASSERT_IMP(a_load_excl, cmd.load, !cmd.div_step && !cmd.emit)

endmodule

FILE: rtl/base58_address_encoder.sv
// After the last byte is accepted the number is divided repeatedly, one byte per division step,
// and then the characters follow at one character per cycle while out_ready is high.
// A new address is accepted only after the last character of the previous one has been emitted,
// since the single byte-wide divide-by-58 unit and the number buffer serve one address at a time.
// Reset (rst_n low, asynchronous) empties the byte count and drops any word in progress.
// ---------------------------------------------------------------------------
// Base58 address encoder
// Buffers a big-endian number byte by byte, converts it to base58 by repeated
// long division and returns it as ASCII characters, most significant first.
// ---------------------------------------------------------------------------
module base58_address_encoder #(
    parameter int NUMBER_BYTES = 25,
    parameter int OUTPUT_CHARS = 34
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] char_code,
    output logic       last_char
);
    import b58e_pkg::*;

    b58e_cmd_t cmd;

    // Sequencer.
    b58e_ctrl #(
        .NUMBER_BYTES (NUMBER_BYTES),
        .OUTPUT_CHARS (OUTPUT_CHARS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Buffer, divider and output register.
    b58e_dp #(
        .NUMBER_BYTES (NUMBER_BYTES),
        .OUTPUT_CHARS (OUTPUT_CHARS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .byte_value (byte_value),
        .char_code  (char_code),
        .last_char  (last_char)
    );

endmodule

FILE: dv/base58_address_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Base58 address encoder testbench
// Streams whole numbers into the encoder byte by byte and checks every
// returned character against a local long-division predictor. Both sides
// idle at random, except near the end of the run.
// ---------------------------------------------------------------------------
module base58_address_encoder_tb;

    localparam int NUM_BYTES    = 25;
    localparam int NUM_CHARS    = 34;
    localparam int BASE         = 58;
    localparam int NUM_ADDRS    = 9;
    localparam int CALM_TAIL    = 2 * NUM_BYTES;
    localparam int DRAIN_CYCLES = 1000;
    localparam string B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    // Shapes of the numbers fed to the encoder.
    typedef enum int {
        NUM_RANDOM,
        NUM_LEAD_ZERO,
        NUM_ZERO,
        NUM_ALL_ONES,
        NUM_ONE_BIT
    } number_kind_t;

    // One expected character word.
    typedef struct packed {
        logic [6:0] code;
        logic       is_last;
    } b58_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [6:0] char_code;
    logic       last_char;

    logic [7:0] byte_queue [$];
    b58_char_t  char_queue [$];
    logic [7:0] number_buf [NUM_BYTES];
    int         fill_count = 0;
    int         bytes_total = 0;
    int         bytes_taken = 0;
    int         err_count = 0;
    int         in_gap = 0;
    int         out_stall = 0;
    bit         in_taken = 1'b0;
    b58_char_t  want;

    base58_address_encoder #(
        .NUMBER_BYTES (NUM_BYTES),
        .OUTPUT_CHARS (NUM_CHARS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Buffer one byte; on the last byte of a number, divide it by 58 again
    // and again and queue the characters, most significant digit first.
    task automatic take_number_byte(input logic [7:0] b);
        int unsigned work [NUM_BYTES];
        int unsigned digit [NUM_CHARS];
        int unsigned rem;
        int unsigned part;
        b58_char_t   c;
        number_buf[fill_count] = b;
        fill_count++;
        if (fill_count == NUM_BYTES)
        begin
            fill_count = 0;
            for (int k = 0; k < NUM_BYTES; k++)
            begin
                work[k] = number_buf[k];
            end
            for (int i = 0; i < NUM_CHARS; i++)
            begin
                rem = work[0] % BASE;
                work[0] = work[0] / BASE;
                for (int k = 1; k < NUM_BYTES; k++)
                begin
                    part = rem * 24 + work[k];
                    work[k] = (rem * 4 + part / BASE) & 8'hFF;
                    rem = part % BASE;
                end
                digit[i] = rem;
            end
            for (int i = NUM_CHARS - 1; i >= 0; i--)
            begin
                c.code = 7'(B58_ALPHABET[int'(digit[i])]);
                c.is_last = (i == 0);
                char_queue.push_back(c);
            end
        end
    endtask

    // Queue the bytes of one whole number of the given shape.
    task automatic queue_number(input number_kind_t kind);
        int unsigned lead;
        int unsigned hot;
        logic [7:0]  b;
        lead = $urandom_range(1, NUM_BYTES - 1);
        hot = $urandom_range(0, NUM_BYTES * 8 - 1);
        for (int k = 0; k < NUM_BYTES; k++)
        begin
            case (kind)
                NUM_LEAD_ZERO: b = (k < lead) ? 8'h00 : 8'($urandom_range(0, 255));
                NUM_ZERO:      b = 8'h00;
                NUM_ALL_ONES:  b = 8'hFF;
                NUM_ONE_BIT:   b = (k == hot / 8) ? 8'(1 << (7 - hot % 8)) : 8'h00;
                default:       b = 8'($urandom_range(0, 255));
            endcase
            byte_queue.push_back(b);
        end
        bytes_total += NUM_BYTES;
    endtask

    // Input driver: holds a word until it is taken, then either pauses for a
    // burst or presents the next byte.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (byte_queue.size() > 0)
            begin
                in_valid <= 1'b1;
                byte_value <= byte_queue.pop_front();
                if (byte_queue.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                begin
                    in_gap = $urandom_range(1, 11);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: stalls in bursts while there is still stimulus well ahead.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (byte_queue.size() > CALM_TAIL && $urandom_range(0, 6) == 0)
                begin
                    out_stall = $urandom_range(1, 11);
                end
            end
        end
    end

    // Monitor: feeds taken bytes to the predictor and checks each character.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                take_number_byte(byte_value);
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (char_queue.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                             $time, char_code, last_char);
                    err_count++;
                end
                else
                begin
                    want = char_queue.pop_front();
                    if (char_code !== want.code)
                    begin
                        $display("%0t: char_code mismatch: expected %0d, actual %0d",
                                 $time, want.code, char_code);
                        err_count++;
                    end
                    if (last_char !== want.is_last)
                    begin
                        $display("%0t: last_char mismatch: expected %0b, actual %0b",
                                 $time, want.is_last, last_char);
                        err_count++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        // Directed: the largest number, whose top digits do not fit.
        queue_number(NUM_ALL_ONES);
        // Short numbers that turn into leading '1' characters.
        queue_number(NUM_ZERO);
        queue_number(NUM_LEAD_ZERO);
        for (int a = 3; a < NUM_ADDRS; a++)
        begin
            case ($urandom_range(0, 9))
                6:       queue_number(NUM_LEAD_ZERO);
                7:       queue_number(NUM_ONE_BIT);
                8:       queue_number(NUM_ALL_ONES);
                9:       queue_number(NUM_ZERO);
                default: queue_number(NUM_RANDOM);
            endcase
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (bytes_taken == bytes_total);
        while (char_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
        begin
            $display("[base58_address_encoder] OK");
        end
        else
        begin
            $display("[base58_address_encoder] ERROR");
        end
        $finish;
    end

    // Timeout well beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("[base58_address_encoder] ERROR");
        $finish;
    end

endmodule

FILE: base58_address_encoder.f
+incdir+rtl
rtl/b58e_pkg.sv
rtl/b58e_dp.sv
rtl/b58e_ctrl.sv
rtl/base58_address_encoder.sv
dv/base58_address_encoder_tb.sv
